// ----- sv/ivs_pkg.sv -----
// ivs_pkg: shared types and codes for the indexed vector store
// used by ivs_cell, ivs_ctrl and indexed_vector_store; depends on nothing
`default_nettype none

package ivs_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_INSERT = 3'd4,
    OP_ERASE  = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_ERASE  = 2'd3
  } cell_op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t            op;
    logic [WORD_W-1:0]   value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- sv/indexed_vector_store.sv -----
// indexed_vector_store: top level, a row of DEPTH entry cells under one controller
// depends on ivs_pkg, ivs_cell and ivs_ctrl
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata: opcode, index, write_value
//   m_*      out  m_tvalid/m_tready  m_tdata: status, read_value, count
//
// push, write, insert, erase, clear, no-op and any failed request: result registered
// in the cycle after the item is taken; insert and erase shift the whole row at once
// read and pop: result once the scan of the registered read bus has walked the row
// one item in flight; a new item is taken once the result register is free
// or being emptied in the same cycle
// rst is synchronous; it clears the count and the handshake, not the entries
`default_nettype none

module indexed_vector_store #(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // opcode[2:0], index[9:3], write_value[41:10], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // status[1:0], read_value[33:2], count[40:34], zero pad
);

  localparam int AW = $clog2(DEPTH);
  localparam int WW = ivs_pkg::WORD_W;

  ivs_pkg::cell_cmd_t cmd;
  logic [AW-1:0]      tgt;
  logic [AW-1:0]      rd_idx;
  logic [1:0]         status;
  logic [WW-1:0]      read_value;
  logic [6:0]         count;

  logic [WW-1:0] cell_data [DEPTH];
  logic [WW-1:0] rd_bus    [DEPTH+1];

  assign rd_bus[0] = '0;

  ivs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .opcode      (s_tdata[2:0]),
    .index       (s_tdata[9:3]),
    .write_value (s_tdata[41:10]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .status      (status),
    .read_value  (read_value),
    .count       (count),
    .cmd         (cmd),
    .tgt         (tgt),
    .rd_idx      (rd_idx),
    .rd_data     (rd_bus[DEPTH])
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WW-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end

    ivs_cell #(
      .DEPTH (DEPTH),
      .POS   (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .tgt        (tgt),
      .left_data  (left_d),
      .right_data (right_d),
      .rd_idx     (rd_idx),
      .rd_in      (rd_bus[g]),
      .data       (cell_data[g]),
      .rd_out     (rd_bus[g+1])
    );
  end

  assign m_tdata = {7'd0, count, read_value, status};

endmodule

`default_nettype wire

// ----- sv/ivs_cell.sv -----
// ivs_cell: one entry of the store, shifts with its neighbors on insert/erase
// and forwards the registered read bus; depends on ivs_pkg
`default_nettype none

module ivs_cell #(
  parameter int DEPTH = 64,
  parameter int POS   = 0
) (
  input  wire logic                          clk,
  input  wire ivs_pkg::cell_cmd_t            cmd,
  input  wire logic [$clog2(DEPTH)-1:0]      tgt,
  input  wire logic [ivs_pkg::WORD_W-1:0]    left_data,
  input  wire logic [ivs_pkg::WORD_W-1:0]    right_data,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_idx,
  input  wire logic [ivs_pkg::WORD_W-1:0]    rd_in,
  output logic      [ivs_pkg::WORD_W-1:0]    data,
  output logic      [ivs_pkg::WORD_W-1:0]    rd_out
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] MY_POS = AW'(POS);

  logic [ivs_pkg::WORD_W-1:0] data_next;

  always_comb begin
    data_next = data;
    unique case (cmd.op)
      ivs_pkg::CELL_HOLD: begin
        data_next = data;
      end
      ivs_pkg::CELL_WRITE: begin
        if (MY_POS == tgt) data_next = cmd.value;
      end
      ivs_pkg::CELL_INSERT: begin
        if (MY_POS == tgt) data_next = cmd.value;
        else if (MY_POS > tgt) data_next = left_data;
      end
      ivs_pkg::CELL_ERASE: begin
        if (MY_POS >= tgt) data_next = right_data;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    // read bus: take own word when addressed, else pass the neighbor's on
    rd_out <= (MY_POS == rd_idx) ? data : rd_in;
  end

endmodule

`default_nettype wire

// ----- sv/ivs_ctrl.sv -----
// ivs_ctrl: request decode, fill count, scan sequencer and result register
// for the indexed vector store; depends on ivs_pkg
`default_nettype none

module ivs_ctrl #(
  parameter int DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [2:0]                   opcode,
  input  wire logic [6:0]                   index,
  input  wire logic [ivs_pkg::WORD_W-1:0]   write_value,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [1:0]                        status,
  output logic [ivs_pkg::WORD_W-1:0]        read_value,
  output logic [6:0]                        count,
  output ivs_pkg::cell_cmd_t                cmd,
  output logic [$clog2(DEPTH)-1:0]          tgt,
  output logic [$clog2(DEPTH)-1:0]          rd_idx,
  input  wire logic [ivs_pkg::WORD_W-1:0]   rd_data
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ivs_pkg::state_t state, state_next;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] scan_cnt;
  logic             in_acc;
  logic             scan_done;

  // decode of the request at the input
  logic [CMP_W-1:0]       idx_c, cnt_c;
  ivs_pkg::status_t       dec_status;
  ivs_pkg::cell_op_t      dec_op;
  logic                   dec_scan;
  logic [CNT_W-1:0]       dec_cnt;
  logic [AW-1:0]          dec_tgt;
  logic [AW-1:0]          dec_rd;
  logic                   full, empty;

  assign in_acc    = s_tvalid & s_tready;
  assign scan_done = (state == ivs_pkg::S_SCAN) && (scan_cnt == CNT_FULL);
  assign idx_c     = CMP_W'(index);
  assign cnt_c     = CMP_W'(cnt);
  assign full      = (cnt == CNT_FULL);
  assign empty     = (cnt == '0);

  always_comb begin
    dec_status = ivs_pkg::ST_OK;
    dec_op     = ivs_pkg::CELL_HOLD;
    dec_scan   = 1'b0;
    dec_cnt    = cnt;
    dec_tgt    = idx_c[AW-1:0];
    dec_rd     = idx_c[AW-1:0];
    unique case (ivs_pkg::op_t'(opcode))
      ivs_pkg::OP_PUSH: begin
        dec_tgt = cnt_c[AW-1:0];
        if (full) begin
          dec_status = ivs_pkg::ST_FULL;
        end else begin
          dec_op  = ivs_pkg::CELL_INSERT;
          dec_cnt = cnt + CNT_W'(1);
        end
      end
      ivs_pkg::OP_POP: begin
        // last stored entry
        dec_rd = AW'(cnt - CNT_W'(1));
        if (empty) begin
          dec_status = ivs_pkg::ST_EMPTY;
        end else begin
          dec_scan = 1'b1;
          dec_cnt  = cnt - CNT_W'(1);
        end
      end
      ivs_pkg::OP_READ: begin
        if (idx_c >= cnt_c) dec_status = ivs_pkg::ST_RANGE;
        else dec_scan = 1'b1;
      end
      ivs_pkg::OP_WRITE: begin
        if (idx_c >= cnt_c) dec_status = ivs_pkg::ST_RANGE;
        else dec_op = ivs_pkg::CELL_WRITE;
      end
      ivs_pkg::OP_INSERT: begin
        priority if (idx_c > cnt_c) begin
          dec_status = ivs_pkg::ST_RANGE;
        end else if (full) begin
          dec_status = ivs_pkg::ST_FULL;
        end else begin
          dec_op  = ivs_pkg::CELL_INSERT;
          dec_cnt = cnt + CNT_W'(1);
        end
      end
      ivs_pkg::OP_ERASE: begin
        if (idx_c >= cnt_c) begin
          dec_status = ivs_pkg::ST_RANGE;
        end else begin
          dec_op  = ivs_pkg::CELL_ERASE;
          dec_cnt = cnt - CNT_W'(1);
        end
      end
      ivs_pkg::OP_CLEAR: begin
        dec_cnt = '0;
      end
      ivs_pkg::OP_NOP: begin
        dec_cnt = cnt;
      end
      default: dec_cnt = cnt;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ivs_pkg::S_IDLE: if (in_acc && dec_scan) state_next = ivs_pkg::S_SCAN;
      ivs_pkg::S_SCAN: if (scan_done) state_next = ivs_pkg::S_IDLE;
      default:         state_next = ivs_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    cmd.op    = ivs_pkg::CELL_HOLD;
    cmd.value = write_value;
    tgt       = dec_tgt;
    unique case (state)
      ivs_pkg::S_IDLE: begin
        s_tready = ~m_tvalid | m_tready;
        if (in_acc) cmd.op = dec_op;
      end
      ivs_pkg::S_SCAN: begin
        s_tready = 1'b0;
      end
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ivs_pkg::S_IDLE;
      cnt      <= '0;
      scan_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) cnt <= dec_cnt;
      if (state == ivs_pkg::S_SCAN) scan_cnt <= scan_cnt + CNT_W'(1);
      else scan_cnt <= '0;
      if ((in_acc && !dec_scan) || scan_done) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  logic [CMP_W-1:0] dec_cnt_c, cnt_now_c;
  assign dec_cnt_c = CMP_W'(dec_cnt);
  assign cnt_now_c = CMP_W'(cnt);

  always_ff @(posedge clk) begin
    if (in_acc) rd_idx <= dec_rd;
    if (in_acc && !dec_scan) begin
      status     <= dec_status;
      read_value <= '0;
      count      <= dec_cnt_c[6:0];
    end else if (scan_done) begin
      status     <= ivs_pkg::ST_OK;
      read_value <= rd_data;
      count      <= cnt_now_c[6:0];
    end
  end

  // the fill count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_FULL)
    else $error("fill count above capacity");

  // a finished scan always leaves a result behind
  a_scan_result: assert property (@(posedge clk) disable iff (rst)
    scan_done |=> m_tvalid && (status == ivs_pkg::ST_OK))
    else $error("scan finished without result");

  // a waiting result blocks new items
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !in_acc)
    else $error("item taken while result stalled");

  // failed requests never return a word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (status != ivs_pkg::ST_OK)) |-> (read_value == '0))
    else $error("nonzero word with error status");

  // a scan never starts while the count is zero
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (in_acc && dec_scan) |-> !empty)
    else $error("scan on empty store");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for indexed_vector_store, stream in and stream out
// depends on ivs_pkg and the indexed_vector_store rtl; the expected result of every item
// comes from a shadow copy of the store kept inside the bench
`default_nettype none

module tb;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  typedef struct packed {
    ivs_pkg::op_t     op;
    ivs_pkg::status_t status;
    logic [31:0]      read_value;
    logic [6:0]       count;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  // shadow of the block's contents
  logic [31:0] shadow_words [DEPTH];
  int          shadow_count = 0;

  logic [47:0] outgoing_items [$];
  outcome_t    expected_outcomes [$];
  int          plan_fill = 0;
  int          planned_items = 0;

  int          cycles = 0;
  int          mismatches = 0;
  int          results_checked = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int          peak_fill = 0;
  logic        item_taken = 1'b0;

  int          tx_burst = 0;
  int          tx_gap = 0;
  int          rx_mode = 0;
  int          rx_mode_left = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  indexed_vector_store #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic outcome_t apply_request(ivs_pkg::op_t op, logic [6:0] idx,
                                             logic [31:0] val);
    outcome_t r;
    int i;
    r.op = op;
    r.status = ivs_pkg::ST_OK;
    r.read_value = '0;
    case (op)
      ivs_pkg::OP_PUSH: begin
        if (shadow_count >= DEPTH) r.status = ivs_pkg::ST_FULL;
        else begin
          shadow_words[shadow_count] = val;
          shadow_count++;
        end
      end
      ivs_pkg::OP_POP: begin
        if (shadow_count == 0) r.status = ivs_pkg::ST_EMPTY;
        else begin
          shadow_count--;
          r.read_value = shadow_words[shadow_count];
        end
      end
      ivs_pkg::OP_READ: begin
        if (idx >= shadow_count) r.status = ivs_pkg::ST_RANGE;
        else r.read_value = shadow_words[idx];
      end
      ivs_pkg::OP_WRITE: begin
        if (idx >= shadow_count) r.status = ivs_pkg::ST_RANGE;
        else shadow_words[idx] = val;
      end
      ivs_pkg::OP_INSERT: begin
        // range is checked before full
        if (idx > shadow_count) r.status = ivs_pkg::ST_RANGE;
        else if (shadow_count >= DEPTH) r.status = ivs_pkg::ST_FULL;
        else begin
          for (i = shadow_count; i > idx; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[idx] = val;
          shadow_count++;
        end
      end
      ivs_pkg::OP_ERASE: begin
        if (idx >= shadow_count) r.status = ivs_pkg::ST_RANGE;
        else begin
          for (i = idx; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      ivs_pkg::OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.count = shadow_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want,
                                 ivs_pkg::op_t op);
    if (mismatches < 30)
      $display("tb: mismatch at cycle %0d on %s for %s: got %0d want %0d",
               cycles, what, op.name(), $signed(got), $signed(want));
    mismatches++;
  endtask

  // queue one item and follow the count so later indexes can aim inside the store
  task automatic add_request(ivs_pkg::op_t op, int idx, logic [31:0] val);
    logic [47:0] item;
    item = {6'b0, val, idx[6:0], op};
    outgoing_items = {outgoing_items, item};
    planned_items++;
    case (op)
      ivs_pkg::OP_PUSH:   if (plan_fill < DEPTH) plan_fill++;
      ivs_pkg::OP_POP:    if (plan_fill > 0) plan_fill--;
      ivs_pkg::OP_INSERT: if (idx <= plan_fill && plan_fill < DEPTH) plan_fill++;
      ivs_pkg::OP_ERASE:  if (idx < plan_fill) plan_fill--;
      ivs_pkg::OP_CLEAR:  plan_fill = 0;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_index(ivs_pkg::op_t op);
    if ($urandom_range(0, 99) < 15) return $urandom_range(0, 127);
    if (op == ivs_pkg::OP_INSERT) return $urandom_range(0, plan_fill);
    if (plan_fill == 0) return 0;
    return $urandom_range(0, plan_fill - 1);
  endfunction

  function automatic ivs_pkg::op_t pick_op(phase_t phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      PH_FILL: begin
        if (r < 40) return ivs_pkg::OP_PUSH;
        if (r < 65) return ivs_pkg::OP_INSERT;
        if (r < 72) return ivs_pkg::OP_POP;
        if (r < 77) return ivs_pkg::OP_ERASE;
        if (r < 87) return ivs_pkg::OP_READ;
        if (r < 97) return ivs_pkg::OP_WRITE;
        return ivs_pkg::OP_NOP;
      end
      PH_DRAIN: begin
        if (r < 40) return ivs_pkg::OP_POP;
        if (r < 65) return ivs_pkg::OP_ERASE;
        if (r < 72) return ivs_pkg::OP_PUSH;
        if (r < 77) return ivs_pkg::OP_INSERT;
        if (r < 87) return ivs_pkg::OP_READ;
        if (r < 97) return ivs_pkg::OP_WRITE;
        return ivs_pkg::OP_NOP;
      end
      default: return ivs_pkg::op_t'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic add_random(phase_t phase);
    ivs_pkg::op_t op;
    op = pick_op(phase);
    add_request(op, pick_index(op), pick_value());
  endtask

  // stimulus
  initial begin
    phase_t phase;
    int n;
    // empty store corners
    add_request(ivs_pkg::OP_POP, 0, 32'h1);
    add_request(ivs_pkg::OP_READ, 0, 32'h0);
    add_request(ivs_pkg::OP_WRITE, 0, 32'h2);
    add_request(ivs_pkg::OP_ERASE, 0, 32'h0);
    add_request(ivs_pkg::OP_INSERT, 1, 32'h3);
    add_request(ivs_pkg::OP_NOP, 127, 32'hffff_ffff);
    // insert at the end behaves like push
    add_request(ivs_pkg::OP_INSERT, 0, 32'h8000_0000);
    add_request(ivs_pkg::OP_PUSH, 0, 32'h7fff_ffff);
    add_request(ivs_pkg::OP_PUSH, 85, 32'h0);
    add_request(ivs_pkg::OP_PUSH, 42, 32'hffff_ffff);
    add_request(ivs_pkg::OP_READ, 0, 32'h0);
    add_request(ivs_pkg::OP_READ, 3, 32'h0);
    add_request(ivs_pkg::OP_READ, 4, 32'h0);
    add_request(ivs_pkg::OP_WRITE, 1, 32'h1234_5678);
    add_request(ivs_pkg::OP_INSERT, 1, 32'h5a5a_5a5a);
    add_request(ivs_pkg::OP_INSERT, 5, 32'ha5a5_a5a5);
    add_request(ivs_pkg::OP_READ, 2, 32'h0);
    add_request(ivs_pkg::OP_ERASE, 0, 32'h0);
    add_request(ivs_pkg::OP_ERASE, 4, 32'h0);
    add_request(ivs_pkg::OP_READ, 127, 32'h0);
    add_request(ivs_pkg::OP_POP, 0, 32'h0);
    add_request(ivs_pkg::OP_CLEAR, 0, 32'h0);
    add_request(ivs_pkg::OP_READ, 0, 32'h0);
    add_request(ivs_pkg::OP_POP, 0, 32'h0);
    n = planned_items + RANDOM_ITEMS;
    phase = PH_FILL;
    while (planned_items < n) begin
      case (phase)
        PH_FILL: begin
          while (plan_fill < DEPTH) add_random(PH_FILL);
          add_request(ivs_pkg::OP_PUSH, pick_index(ivs_pkg::OP_PUSH), pick_value());
          add_request(ivs_pkg::OP_INSERT, $urandom_range(0, DEPTH), pick_value());
          add_request(ivs_pkg::OP_INSERT, $urandom_range(DEPTH + 1, 127), pick_value());
          add_request(ivs_pkg::OP_READ, DEPTH - 1, 32'h0);
        end
        PH_DRAIN: begin
          while (plan_fill > 0) add_random(PH_DRAIN);
          add_request(ivs_pkg::OP_POP, 0, pick_value());
          add_request(ivs_pkg::OP_ERASE, 0, pick_value());
        end
        default: repeat ($urandom_range(20, 80)) add_random(PH_MIX);
      endcase
      phase = phase_t'($urandom_range(0, 2));
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (outgoing_items.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);

    $display("tb: %0d items sent, %0d results checked, peak fill %0d of %0d",
             planned_items, results_checked, peak_fill, DEPTH);
    $display("tb: status seen ok %0d, range %0d, full %0d, empty %0d",
             status_seen[ivs_pkg::ST_OK], status_seen[ivs_pkg::ST_RANGE],
             status_seen[ivs_pkg::ST_FULL], status_seen[ivs_pkg::ST_EMPTY]);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // sender: bursts of items with gaps in between
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !item_taken) begin
      // item still waiting for ready
    end else if (tx_burst > 0 && outgoing_items.size() != 0) begin
      s_tdata <= outgoing_items.pop_front();
      s_tvalid <= 1'b1;
      tx_burst--;
    end else begin
      s_tvalid <= 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if ($urandom_range(0, 9) == 0) begin
        tx_burst = 80;
        tx_gap = 0;
      end else begin
        tx_burst = $urandom_range(1, 24);
        tx_gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      end
    end
  end

  // receiver: changing ready density, plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && results_checked >= 250) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(10, 60);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) != 0);
        2: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: check results, then predict for the item taken at this edge
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    outcome_t pred;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: errors");
      $finish;
    end else begin
      item_taken <= s_tvalid && s_tready && !rst;
      if (!rst) begin
        if (m_tvalid && m_tready) begin
          got.status = ivs_pkg::status_t'(m_tdata[1:0]);
          got.read_value = m_tdata[33:2];
          got.count = m_tdata[40:34];
          if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected result", {30'b0, got.status}, 32'h0,
                            ivs_pkg::OP_NOP);
          end else begin
            want = expected_outcomes.pop_front();
            results_checked++;
            status_seen[want.status]++;
            if (got.status != want.status)
              report_mismatch("status", {30'b0, got.status}, {30'b0, want.status}, want.op);
            if (got.read_value != want.read_value)
              report_mismatch("read_value", got.read_value, want.read_value, want.op);
            if (got.count != want.count)
              report_mismatch("count", {25'b0, got.count}, {25'b0, want.count}, want.op);
          end
        end
        if (s_tvalid && s_tready) begin
          pred = apply_request(ivs_pkg::op_t'(s_tdata[2:0]), s_tdata[9:3], s_tdata[41:10]);
          expected_outcomes = {expected_outcomes, pred};
          if (shadow_count > peak_fill) peak_fill = shadow_count;
        end
      end
    end
  end

endmodule

`default_nettype wire
